FILE: rtl/jit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jit_pkg
// Shared widths, pipeline depth, stage types and the Q16.16 saturation helper
// for the 3x3 Jacobian inverse-transpose pipeline.
// ----------------------------------------------------------------------------
package jit_pkg;

    localparam int NLANE     = 9;    // adjugate entries, one divider lane each
    localparam int ADJ_W     = 64;   // adjugate entry, exact Q32.32
    localparam int DET_W     = 98;   // signed determinant, exact Q48.48
    localparam int DM_W      = 97;   // determinant magnitude
    localparam int PM_W      = 63;   // |coef * weight|, exact Q32.32
    localparam int NUM_W     = 98;   // divider numerator and remainder
    localparam int QUO_W     = 32;   // quotient bits kept before saturation
    localparam int DIV_STEPS = QUO_W;
    localparam int SUM_W     = 130;  // one partial row of coef*w*|D|
    localparam int TOT_W     = 163;  // full coef*w*|D| with rounding half

    // register stages from the input edge to the last divider step
    localparam int FRONT_STAGES = 10;
    localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STEPS;

    localparam logic [31:0]      SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0]      SAT_NEG = 32'h8000_0000;
    localparam logic [TOT_W-1:0] SC_HALF = TOT_W'(1) << 63;

    // determinant and adjugate magnitudes travelling alongside the scaling
    typedef struct packed {
        logic [DM_W-1:0]                  dm;
        logic                             zero;
        logic [NLANE-1:0][ADJ_W-1:0]      amag;
        logic [NLANE-1:0]                 neg;
    } det_t;

    // one word in the restoring divider
    typedef struct packed {
        logic [NLANE-1:0][NUM_W-1:0]      rem;
        logic [NLANE-1:0][QUO_W-1:0]      quo;
        logic [NLANE-1:0]                 ovf;
        logic [NLANE-1:0]                 neg;
        logic [NUM_W-1:0]                 dvs;
        logic                             zero;
        logic [31:0]                      lam;
        logic [31:0]                      mu;
    } div_t;

    // clamp an unsigned magnitude with its sign to Q16.16
    function automatic logic [31:0] sat_q(input logic big, input logic [31:0] mag,
                                          input logic neg);
        logic [31:0] res;
        if (neg)
        begin
            if (big || (mag > SAT_NEG))
                res = SAT_NEG;
            else
                res = -mag;
        end
        else
        begin
            if (big || mag[31])
                res = SAT_POS;
            else
                res = mag;
        end
        return res;
    endfunction

endpackage

FILE: rtl/jacobian_inverse_transpose_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobian_inverse_transpose_3x3
// Inverse transpose of a 3x3 Q16.16 Jacobian with lambda*w*det and mu*w*det.
// ----------------------------------------------------------------------------
//
//  channel | handshake         | payload
//  --------+-------------------+---------------------------------------------
//  input   | start / busy      | j11..j33, quad_weight, lambda_coef, mu_coef
//  result  | done (strobe)     | invt_r1c1..invt_r3c3, lambda_scaled,
//          |                   | mu_scaled, singular
//
//  A word is taken at every edge at which start is high and busy is low; its
//  result is on the ports, with done high, once it has passed ten front stages
//  (products, adjugate, determinant and coefficient scaling), 32
//  restoring-division steps (one quotient bit per stage, nine lanes sharing
//  the divisor) and the output register.
//  Reset clears the valid chain; busy stays high until the first edge after
//  reset is released and is low from then on.
//  The receiver cannot stall, so the pipeline advances in every cycle.
//
// Arithmetic: adjugate exact in Q32.32, determinant exact in Q48.48. Each
// inverse entry is floor((|A|*2^33 + |D|) / (2|D|)), which rounds ties away
// from zero, then signed and saturated; the scaled coefficients round
// coef*w*|D| at bit 63 and saturate the same way.
// ----------------------------------------------------------------------------
module jacobian_inverse_transpose_3x3
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] j11,
    input  logic signed [31:0] j21,
    input  logic signed [31:0] j31,
    input  logic signed [31:0] j12,
    input  logic signed [31:0] j22,
    input  logic signed [31:0] j32,
    input  logic signed [31:0] j13,
    input  logic signed [31:0] j23,
    input  logic signed [31:0] j33,
    input  logic        [30:0] quad_weight,
    input  logic signed [31:0] lambda_coef,
    input  logic signed [31:0] mu_coef,
    output logic               done,
    output logic signed [31:0] invt_r1c1,
    output logic signed [31:0] invt_r1c2,
    output logic signed [31:0] invt_r1c3,
    output logic signed [31:0] invt_r2c1,
    output logic signed [31:0] invt_r2c2,
    output logic signed [31:0] invt_r2c3,
    output logic signed [31:0] invt_r3c1,
    output logic signed [31:0] invt_r3c2,
    output logic signed [31:0] invt_r3c3,
    output logic signed [31:0] lambda_scaled,
    output logic signed [31:0] mu_scaled,
    output logic               singular
);

    localparam int NL = jit_pkg::NLANE;

    // ------------------------------------------------------------------
    // control: valid chain and busy
    // ------------------------------------------------------------------
    logic                              busy_reg;
    logic                              accept;
    logic [jit_pkg::PIPE_DEPTH-1:0]    v_reg;
    logic                              done_reg;

    assign accept = start & ~busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            v_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            v_reg    <= {v_reg[jit_pkg::PIPE_DEPTH-2:0], accept};
            done_reg <= v_reg[jit_pkg::PIPE_DEPTH-1];
        end
    end

    // ------------------------------------------------------------------
    // stage 1: the eighteen cofactor products and coef*weight
    // ------------------------------------------------------------------
    logic signed [63:0] pp1_reg [NL][2];
    logic signed [31:0] jc1_reg [3];
    logic signed [63:0] lw1_reg, mw1_reg;
    logic signed [31:0] wq;

    assign wq = $signed({1'b0, quad_weight});

    always_ff @(posedge clk)
    begin
        pp1_reg[0][0] <= 64'(j22) * 64'(j33);  pp1_reg[0][1] <= 64'(j23) * 64'(j32);
        pp1_reg[1][0] <= 64'(j32) * 64'(j13);  pp1_reg[1][1] <= 64'(j12) * 64'(j33);
        pp1_reg[2][0] <= 64'(j12) * 64'(j23);  pp1_reg[2][1] <= 64'(j22) * 64'(j13);
        pp1_reg[3][0] <= 64'(j31) * 64'(j23);  pp1_reg[3][1] <= 64'(j21) * 64'(j33);
        pp1_reg[4][0] <= 64'(j11) * 64'(j33);  pp1_reg[4][1] <= 64'(j13) * 64'(j31);
        pp1_reg[5][0] <= 64'(j21) * 64'(j13);  pp1_reg[5][1] <= 64'(j11) * 64'(j23);
        pp1_reg[6][0] <= 64'(j21) * 64'(j32);  pp1_reg[6][1] <= 64'(j31) * 64'(j22);
        pp1_reg[7][0] <= 64'(j31) * 64'(j12);  pp1_reg[7][1] <= 64'(j11) * 64'(j32);
        pp1_reg[8][0] <= 64'(j11) * 64'(j22);  pp1_reg[8][1] <= 64'(j12) * 64'(j21);
        jc1_reg[0]    <= j11;
        jc1_reg[1]    <= j21;
        jc1_reg[2]    <= j31;
        lw1_reg       <= 64'(lambda_coef) * 64'(wq);
        mw1_reg       <= 64'(mu_coef) * 64'(wq);
    end

    // ------------------------------------------------------------------
    // stage 2: adjugate; entry k is A(k/3+1, k%3+1)
    // ------------------------------------------------------------------
    logic signed [63:0] adj2_reg [NL];
    logic signed [31:0] jc2_reg [3];
    logic signed [63:0] lw2_reg, mw2_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NL; k++)
            adj2_reg[k] <= pp1_reg[k][0] - pp1_reg[k][1];
        jc2_reg <= jc1_reg;
        lw2_reg <= lw1_reg;
        mw2_reg <= mw1_reg;
    end

    // ------------------------------------------------------------------
    // stage 3: first-column terms of the determinant, split in halves
    // ------------------------------------------------------------------
    logic signed [63:0] dh3_reg [3];
    logic signed [63:0] dl3_reg [3];
    logic signed [63:0] adj3_reg [NL];
    logic signed [63:0] lw3_reg, mw3_reg;

    always_ff @(posedge clk)
    begin
        for (int t = 0; t < 3; t++)
        begin
            dh3_reg[t] <= 64'(jc2_reg[t]) * 64'($signed(adj2_reg[t][63:32]));
            dl3_reg[t] <= 64'(jc2_reg[t]) * 64'($signed({1'b0, adj2_reg[t][31:0]}));
        end
        adj3_reg <= adj2_reg;
        lw3_reg  <= lw2_reg;
        mw3_reg  <= mw2_reg;
    end

    // ------------------------------------------------------------------
    // stage 4: join the halves; stage 5: sum the three terms
    // ------------------------------------------------------------------
    logic signed [jit_pkg::DET_W-1:0] dt4_reg [3];
    logic signed [63:0]               adj4_reg [NL];
    logic signed [63:0]               lw4_reg, mw4_reg;
    logic signed [jit_pkg::DET_W-1:0] det5_reg;
    logic signed [63:0]               adj5_reg [NL];
    logic signed [63:0]               lw5_reg, mw5_reg;

    always_ff @(posedge clk)
    begin
        for (int t = 0; t < 3; t++)
            dt4_reg[t] <= (jit_pkg::DET_W'(dh3_reg[t]) <<< 32) + jit_pkg::DET_W'(dl3_reg[t]);
        adj4_reg <= adj3_reg;
        lw4_reg  <= lw3_reg;
        mw4_reg  <= mw3_reg;
        det5_reg <= dt4_reg[0] + dt4_reg[1] + dt4_reg[2];
        adj5_reg <= adj4_reg;
        lw5_reg  <= lw4_reg;
        mw5_reg  <= mw4_reg;
    end

    // ------------------------------------------------------------------
    // stage 6: magnitudes and result signs
    // ------------------------------------------------------------------
    jit_pkg::det_t            det6_next, det6_reg;
    logic [jit_pkg::PM_W-1:0] pm6_next [2];
    logic [jit_pkg::PM_W-1:0] pm6_reg [2];
    logic [1:0]               psg6_next, psg6_reg;

    always_comb
    begin
        logic                        dneg;
        logic [jit_pkg::DET_W-1:0]   dabs;
        logic [63:0]                 pabs0, pabs1;
        dneg           = det5_reg[jit_pkg::DET_W-1];
        dabs           = dneg ? -det5_reg : det5_reg;
        det6_next.dm   = dabs[jit_pkg::DM_W-1:0];
        det6_next.zero = (det5_reg == '0);
        for (int k = 0; k < NL; k++)
        begin
            det6_next.amag[k] = adj5_reg[k][63] ? -adj5_reg[k] : adj5_reg[k];
            det6_next.neg[k]  = adj5_reg[k][63] ^ dneg;
        end
        pabs0        = lw5_reg[63] ? -lw5_reg : lw5_reg;
        pabs1        = mw5_reg[63] ? -mw5_reg : mw5_reg;
        pm6_next[0]  = pabs0[jit_pkg::PM_W-1:0];
        pm6_next[1]  = pabs1[jit_pkg::PM_W-1:0];
        psg6_next[0] = lw5_reg[63] ^ dneg;
        psg6_next[1] = mw5_reg[63] ^ dneg;
    end

    always_ff @(posedge clk)
    begin
        det6_reg <= det6_next;
        pm6_reg  <= pm6_next;
        psg6_reg <= psg6_next;
    end

    // ------------------------------------------------------------------
    // stages 7-9: coef*w*|D| as 32x32 partial products, rows, then total
    // ------------------------------------------------------------------
    jit_pkg::det_t              det7_reg, det8_reg, det9_reg;
    logic [63:0]                xp7_reg [2][2][3];
    logic [31:0]                pk7_reg [2][2];
    logic [1:0]                 psg7_reg, psg8_reg, psg9_reg;
    logic [jit_pkg::SUM_W-1:0]  sk8_reg [2][2];
    logic [jit_pkg::TOT_W-1:0]  tot9_reg [2];
    logic [31:0]                pk6 [2][2];

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            pk6[c][0] = pm6_reg[c][31:0];
            pk6[c][1] = {1'b0, pm6_reg[c][jit_pkg::PM_W-1:32]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 2; c++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                for (int j = 0; j < 3; j++)
                    xp7_reg[c][k][j] <= 64'(pk6[c][k]) * 64'(det6_reg.dm[j*32 +: 32]);
                pk7_reg[c][k] <= pk6[c][k];
                sk8_reg[c][k] <= jit_pkg::SUM_W'(xp7_reg[c][k][0])
                               + (jit_pkg::SUM_W'(xp7_reg[c][k][1]) << 32)
                               + (jit_pkg::SUM_W'(xp7_reg[c][k][2]) << 64)
                               + (det7_reg.dm[jit_pkg::DM_W-1]
                                  ? (jit_pkg::SUM_W'(pk7_reg[c][k]) << 96) : '0);
            end
            tot9_reg[c] <= jit_pkg::TOT_W'(sk8_reg[c][0])
                         + (jit_pkg::TOT_W'(sk8_reg[c][1]) << 32)
                         + jit_pkg::SC_HALF;
        end
        det7_reg <= det6_reg;
        det8_reg <= det7_reg;
        det9_reg <= det8_reg;
        psg7_reg <= psg6_reg;
        psg8_reg <= psg7_reg;
        psg9_reg <= psg8_reg;
    end

    // ------------------------------------------------------------------
    // stage 10: clamp the scaled coefficients, form divider numerators
    // numerator = 2|A|*2^32 + |D|, divisor = 2|D|  (round half away)
    // ------------------------------------------------------------------
    logic [jit_pkg::NUM_W-1:0] n10_reg [NL];
    logic [jit_pkg::NUM_W-1:0] dvs10_reg;
    logic [NL-1:0]             neg10_reg;
    logic                      zero10_reg;
    logic [31:0]               lam10_reg, mu10_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NL; k++)
            n10_reg[k] <= (jit_pkg::NUM_W'(det9_reg.amag[k]) << 33)
                        + jit_pkg::NUM_W'(det9_reg.dm);
        dvs10_reg  <= jit_pkg::NUM_W'(det9_reg.dm) << 1;
        neg10_reg  <= det9_reg.neg;
        zero10_reg <= det9_reg.zero;
        lam10_reg  <= jit_pkg::sat_q(|tot9_reg[0][jit_pkg::TOT_W-1:96],
                                     tot9_reg[0][95:64], psg9_reg[0]);
        mu10_reg   <= jit_pkg::sat_q(|tot9_reg[1][jit_pkg::TOT_W-1:96],
                                     tot9_reg[1][95:64], psg9_reg[1]);
    end

    // ------------------------------------------------------------------
    // divider: one quotient bit per stage, MSB first, nine lanes
    // ------------------------------------------------------------------
    localparam int WIDE_W = jit_pkg::NUM_W + jit_pkg::QUO_W;

    jit_pkg::div_t div_entry;
    jit_pkg::div_t div_reg [jit_pkg::DIV_STEPS];

    // flag quotients of 2^32 or more; they saturate whatever the sign
    always_comb
    begin
        div_entry.dvs  = dvs10_reg;
        div_entry.neg  = neg10_reg;
        div_entry.zero = zero10_reg;
        div_entry.lam  = lam10_reg;
        div_entry.mu   = mu10_reg;
        for (int k = 0; k < NL; k++)
        begin
            div_entry.rem[k] = n10_reg[k];
            div_entry.quo[k] = '0;
            div_entry.ovf[k] = (WIDE_W'(n10_reg[k]) >= (WIDE_W'(dvs10_reg) << jit_pkg::QUO_W));
        end
    end

    for (genvar s = 0; s < jit_pkg::DIV_STEPS; s++)
    begin : g_div
        localparam int B = jit_pkg::DIV_STEPS - 1 - s;
        jit_pkg::div_t      d_in, d_next;
        logic [WIDE_W-1:0]  sh;

        if (s == 0)
        begin : g_first
            assign d_in = div_entry;
        end
        else
        begin : g_rest
            assign d_in = div_reg[s-1];
        end

        assign sh = WIDE_W'(d_in.dvs) << B;

        always_comb
        begin
            logic ge;
            d_next = d_in;
            for (int k = 0; k < NL; k++)
            begin
                ge = (WIDE_W'(d_in.rem[k]) >= sh);
                if (ge)
                    d_next.rem[k] = d_in.rem[k] - sh[jit_pkg::NUM_W-1:0];
                d_next.quo[k] = d_in.quo[k] | (jit_pkg::QUO_W'(ge) << B);
            end
        end

        always_ff @(posedge clk)
        begin
            div_reg[s] <= d_next;
        end
    end

    // ------------------------------------------------------------------
    // output register: clamp, sign, zero on a singular Jacobian
    // ------------------------------------------------------------------
    jit_pkg::div_t last;
    logic [31:0]   inv_next [NL];
    logic [31:0]   inv_reg [NL];
    logic [31:0]   lam_reg, mu_reg;
    logic          sing_reg;

    assign last = div_reg[jit_pkg::DIV_STEPS-1];

    always_comb
    begin
        for (int k = 0; k < NL; k++)
            inv_next[k] = last.zero ? '0
                        : jit_pkg::sat_q(last.ovf[k], last.quo[k], last.neg[k]);
    end

    always_ff @(posedge clk)
    begin
        inv_reg  <= inv_next;
        lam_reg  <= last.lam;
        mu_reg   <= last.mu;
        sing_reg <= last.zero;
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    // entry (r,c) of the inverse transpose is A(c,r)/D
    assign invt_r1c1     = $signed(inv_reg[0]);
    assign invt_r1c2     = $signed(inv_reg[3]);
    assign invt_r1c3     = $signed(inv_reg[6]);
    assign invt_r2c1     = $signed(inv_reg[1]);
    assign invt_r2c2     = $signed(inv_reg[4]);
    assign invt_r2c3     = $signed(inv_reg[7]);
    assign invt_r3c1     = $signed(inv_reg[2]);
    assign invt_r3c2     = $signed(inv_reg[5]);
    assign invt_r3c3     = $signed(inv_reg[8]);
    assign lambda_scaled = $signed(lam_reg);
    assign mu_scaled     = $signed(mu_reg);
    assign singular      = sing_reg;

endmodule

FILE: rtl/jit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jit_checker
// Port-level checks on latency, busy and the singular result.
// ----------------------------------------------------------------------------
module jit_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] invt_r1c1,
    input logic signed [31:0] invt_r1c2,
    input logic signed [31:0] invt_r1c3,
    input logic signed [31:0] invt_r2c1,
    input logic signed [31:0] invt_r2c2,
    input logic signed [31:0] invt_r2c3,
    input logic signed [31:0] invt_r3c1,
    input logic signed [31:0] invt_r3c2,
    input logic signed [31:0] invt_r3c3,
    input logic signed [31:0] lambda_scaled,
    input logic signed [31:0] mu_scaled,
    input logic               singular
);

    localparam int LAT = jit_pkg::PIPE_DEPTH + 1;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result word missing after accepted word");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result word without accepted word");

    a_busy_stays_low: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy rose outside reset");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && singular) |->
            invt_r1c1 == 0 && invt_r1c2 == 0 && invt_r1c3 == 0 &&
            invt_r2c1 == 0 && invt_r2c2 == 0 && invt_r2c3 == 0 &&
            invt_r3c1 == 0 && invt_r3c2 == 0 && invt_r3c3 == 0 &&
            lambda_scaled == 0 && mu_scaled == 0)
        else $error("singular result with nonzero entries");

endmodule

bind jacobian_inverse_transpose_3x3 jit_checker u_jit_checker (.*);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 Jacobian inverse-transpose pipeline.
// A directed table covers identity, zero, extreme and saturating Jacobians,
// followed by random words (bounded, singular, tiny and raw). Every
// accepted word is checked field by field against the result strobed on done;
// the expectation comes from the table or from exact wide integer arithmetic.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [31:0] ONE_Q = 32'h0001_0000;   // 1.0 in Q16.16
    localparam int          N_RANDOM = 1240;

    // one input word: Jacobian entries in port order j11 j21 j31 j12 .. j33
    typedef struct packed {
        logic [8:0][31:0] jac;
        logic [30:0]      wgt;
        logic [31:0]      lam;
        logic [31:0]      mu;
    } point_t;

    // one result: inverse-transpose entries in port order r1c1 .. r3c3
    typedef struct packed {
        logic [8:0][31:0] invt;
        logic [31:0]      lam_s;
        logic [31:0]      mu_s;
        logic             sing;
    } invt_t;

    typedef struct packed {
        point_t pt;
        logic   typed;     // expected result written in the table
        invt_t  res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    point_t drv = '0;
    invt_t  got;

    invt_t  pending_results[$];
    int     fails = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    jacobian_inverse_transpose_3x3 uut
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .j11(drv.jac[0]), .j21(drv.jac[1]), .j31(drv.jac[2]),
        .j12(drv.jac[3]), .j22(drv.jac[4]), .j32(drv.jac[5]),
        .j13(drv.jac[6]), .j23(drv.jac[7]), .j33(drv.jac[8]),
        .quad_weight(drv.wgt), .lambda_coef(drv.lam), .mu_coef(drv.mu),
        .done(done),
        .invt_r1c1(got.invt[0]), .invt_r1c2(got.invt[1]), .invt_r1c3(got.invt[2]),
        .invt_r2c1(got.invt[3]), .invt_r2c2(got.invt[4]), .invt_r2c3(got.invt[5]),
        .invt_r3c1(got.invt[6]), .invt_r3c2(got.invt[7]), .invt_r3c3(got.invt[8]),
        .lambda_scaled(got.lam_s), .mu_scaled(got.mu_s), .singular(got.sing)
    );

    // clamp a magnitude with its sign to Q16.16
    function automatic logic [31:0] clamp_q(input logic [191:0] mag, input logic neg);
        logic [191:0] lim;
        logic [191:0] m;
        lim = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
        m = (mag > lim) ? lim : mag;
        return neg ? 32'(-m[31:0]) : m[31:0];
    endfunction

    // round(coef * w * |D| / 2^64), ties away from zero
    function automatic logic [31:0] scale_coef(input logic [31:0] coef, input logic [30:0] w,
                                               input logic [127:0] dm, input logic dneg);
        longint       p;
        logic [191:0] pm;
        logic [191:0] x;
        p = longint'($signed(coef)) * longint'({1'b0, w});
        pm = (p < 0) ? 192'(-p) : 192'(p);
        x = pm * 192'(dm) + (192'(1) << 63);
        return clamp_q(x >> 64, (p < 0) != dneg);
    endfunction

    // inverse transpose of J plus the scaled coefficients
    function automatic invt_t invert_point(input point_t pt);
        invt_t                res;
        longint               j[9];
        longint               adj[9];   // a11 a21 a31 a12 a22 a32 a13 a23 a33
        logic signed [127:0]  det;
        logic [127:0]         dm;
        logic [127:0]         am;
        logic [127:0]         q;
        logic                 dneg;
        for (int k = 0; k < 9; k++)
            j[k] = longint'($signed(pt.jac[k]));
        // j[0]=j11 j[1]=j21 j[2]=j31 j[3]=j12 j[4]=j22 j[5]=j32 j[6]=j13 j[7]=j23 j[8]=j33
        adj[0] = j[4] * j[8] - j[7] * j[5];   // a11
        adj[1] = j[2] * j[7] - j[1] * j[8];   // a21
        adj[2] = j[1] * j[5] - j[2] * j[4];   // a31
        adj[3] = j[5] * j[6] - j[3] * j[8];   // a12
        adj[4] = j[0] * j[8] - j[6] * j[2];   // a22
        adj[5] = j[2] * j[3] - j[0] * j[5];   // a32
        adj[6] = j[3] * j[7] - j[4] * j[6];   // a13
        adj[7] = j[1] * j[6] - j[0] * j[7];   // a23
        adj[8] = j[0] * j[4] - j[3] * j[1];   // a33
        det = 128'(j[0]) * 128'(adj[0]) + 128'(j[1]) * 128'(adj[3])
            + 128'(j[2]) * 128'(adj[6]);
        dneg = det < 0;
        dm = dneg ? 128'(-det) : 128'(det);
        res.sing = (dm == 0);
        for (int k = 0; k < 9; k++)
        begin
            if (res.sing)
                res.invt[k] = '0;
            else
            begin
                am = (adj[k] < 0) ? 128'(-adj[k]) : 128'(adj[k]);
                q = ((am << 33) + dm) / (dm << 1);
                res.invt[k] = clamp_q(192'(q), (adj[k] < 0) != dneg);
            end
        end
        res.lam_s = scale_coef(pt.lam, pt.wgt, dm, dneg);
        res.mu_s = scale_coef(pt.mu, pt.wgt, dm, dneg);
        return res;
    endfunction

    function automatic point_t diag_point(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
        point_t pt;
        pt = '0;
        pt.jac[0] = a;
        pt.jac[4] = b;
        pt.jac[8] = c;
        pt.wgt = 31'(ONE_Q);
        pt.lam = 32'h0002_0000;
        pt.mu = 32'hFFFF_0000;
        return pt;
    endfunction

    // random word: bounded, tiny or raw Jacobians, some of them singular
    function automatic point_t random_point();
        point_t pt;
        int     mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++)
        begin
            case (mode)
                0, 1, 2, 3: pt.jac[k] = 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000);
                4:          pt.jac[k] = 32'($signed($urandom_range(0, 32)) - 16);
                default:    pt.jac[k] = $urandom;
            endcase
        end
        // singular: repeat one column in another
        if (mode == 3 || mode == 5)
        begin
            pt.jac[6] = pt.jac[0];
            pt.jac[7] = pt.jac[1];
            pt.jac[8] = pt.jac[2];
        end
        pt.wgt = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0002_0000));
        pt.lam = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000);
        pt.mu = $urandom;
        return pt;
    endfunction

    // hand one word over and wait for the edge that takes it
    task automatic send_point(input point_t pt, input logic typed, input invt_t want);
        int gap;
        drv <= pt;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_results.insert(pending_results.size(), typed ? want : invert_point(pt));
        gap = $urandom_range(0, 11);
        if (gap > 0)
        begin
            start <= 1'b0;
            drv <= '{jac: {9{32'hDEAD_BEEF}}, wgt: 31'h5A5A_5A5A, lam: 32'hA5A5_A5A5, mu: 32'h0F0F_F0F0};
            repeat (gap) @(posedge clk);
        end
    endtask

    // check each strobed result against the oldest expectation
    always @(posedge clk)
    begin
        invt_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no word outstanding");
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got.invt[k] !== want.invt[k])
                    begin
                        $error("invt_r%0dc%0d: expected %h, got %h", k / 3 + 1, k % 3 + 1,
                               want.invt[k], got.invt[k]);
                        fails++;
                    end
                if (got.lam_s !== want.lam_s)
                begin
                    $error("lambda_scaled: expected %h, got %h", want.lam_s, got.lam_s);
                    fails++;
                end
                if (got.mu_s !== want.mu_s)
                begin
                    $error("mu_scaled: expected %h, got %h", want.mu_s, got.mu_s);
                    fails++;
                end
                if (got.sing !== want.sing)
                begin
                    $error("singular: expected %b, got %b", want.sing, got.sing);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        row_t   table_rows[$];
        row_t   r;
        point_t pt;
        int     guard;

        // identity: inverse is identity, D = 1.0
        r = '0;
        r.pt = diag_point(ONE_Q, ONE_Q, ONE_Q);
        r.typed = 1'b1;
        r.res.invt[0] = ONE_Q;
        r.res.invt[4] = ONE_Q;
        r.res.invt[8] = ONE_Q;
        r.res.lam_s = 32'h0002_0000;
        r.res.mu_s = 32'hFFFF_0000;
        table_rows.insert(table_rows.size(), r);
        // zero Jacobian: singular, everything zero
        r = '0;
        r.pt = diag_point(32'h0, 32'h0, 32'h0);
        r.typed = 1'b1;
        r.res.sing = 1'b1;
        table_rows.insert(table_rows.size(), r);
        // one-LSB diagonal: inverse saturates positive, scaled terms round to zero
        r = '0;
        r.pt = diag_point(32'h1, 32'h1, 32'h1);
        r.typed = 1'b1;
        r.res.invt[0] = 32'h7FFF_FFFF;
        r.res.invt[4] = 32'h7FFF_FFFF;
        r.res.invt[8] = 32'h7FFF_FFFF;
        table_rows.insert(table_rows.size(), r);
        // reflection of the first axis: one negative entry
        r = '0;
        r.pt = diag_point(32'hFFFF_0000, ONE_Q, ONE_Q);
        r.typed = 1'b1;
        r.res.invt[0] = 32'hFFFF_0000;
        r.res.invt[4] = ONE_Q;
        r.res.invt[8] = ONE_Q;
        r.res.lam_s = 32'hFFFE_0000;
        r.res.mu_s = ONE_Q;
        table_rows.insert(table_rows.size(), r);
        // remaining rows go through the predictor
        r = '0;
        r.pt = diag_point(32'h0000_8000, 32'h0002_0000, 32'hFFFF_C000);
        table_rows.insert(table_rows.size(), r);
        r.pt = diag_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        r.pt.wgt = 31'h7FFF_FFFF;
        r.pt.lam = 32'h7FFF_FFFF;
        r.pt.mu = 32'h8000_0000;
        table_rows.insert(table_rows.size(), r);
        r.pt = diag_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        r.pt.wgt = 31'h7FFF_FFFF;
        r.pt.lam = 32'h8000_0000;
        r.pt.mu = 32'h7FFF_FFFF;
        table_rows.insert(table_rows.size(), r);
        r.pt.jac = {9{32'h8000_0000}};
        table_rows.insert(table_rows.size(), r);
        r.pt.jac = {9{32'hFFFF_FFFF}};
        table_rows.insert(table_rows.size(), r);
        r.pt = diag_point(32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0007);
        r.pt.jac[1] = 32'h8000_0000;
        r.pt.jac[5] = 32'h7FFF_FFFF;
        r.pt.jac[6] = 32'h0000_0001;
        table_rows.insert(table_rows.size(), r);
        r.pt = diag_point(32'h0003_0000, 32'h0003_0000, 32'h0003_0000);   // rounds on a third
        table_rows.insert(table_rows.size(), r);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
            send_point(table_rows[i].pt, table_rows[i].typed, table_rows[i].res);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            pt = random_point();
            send_point(pt, 1'b0, '0);
        end
        start <= 1'b0;

        // drain, then allow the pipeline depth for any stray strobe
        guard = 0;
        while (pending_results.size() != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (60) @(posedge clk);
        if (fails == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
